FILE: design/qmpd_pkg.sv
// ----------------------------------------------------------------------------
// qmpd_pkg
// Shared types and constants for the quad motor PD mixer.
// ----------------------------------------------------------------------------
package qmpd_pkg;

    localparam int NUM_STAGES = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam int GAIN_W  = 10;
    localparam int BASE_W  = 8;
    localparam int STEER_W = 9;
    localparam int SAMP_W  = 16;
    localparam int THR_W   = 16;

    localparam int PROD_W  = 27;    // sample times gain
    localparam int X_W     = 27;    // PD sum per axis
    localparam int K_W     = 20;    // base and steering part of the numerator
    localparam int MP_W    = 36;    // PD sum times (255 - base)
    localparam int T_W     = 37;    // full numerator over 255000
    localparam int TL_W    = 18;    // numerator once known to lie in 1..254999
    localparam int M_W     = 31;    // reduced dividend
    localparam int Q_W     = 17;    // quotient, up to 65536
    localparam int QM_W    = 48;    // dividend times reciprocal
    localparam int QD_W    = 32;    // quotient times divisor
    localparam int FRAC_SH = 13;

    typedef logic [NUM_STAGES:1] stage_vec_t;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_ARM    = 2'd1,
        OP_STOP   = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_P_GAIN      = 3'd0,
        REG_D_GAIN      = 3'd1,
        REG_BASE_LEVEL  = 3'd2,
        REG_NORTH_STEER = 3'd3,
        REG_EAST_STEER  = 3'd4
    } reg_idx_t;

    localparam logic [GAIN_W-1:0]         P_GAIN_RST     = 10'd20;
    localparam logic [GAIN_W-1:0]         D_GAIN_RST     = 10'd20;
    localparam logic [BASE_W-1:0]         BASE_RST       = 8'd26;
    localparam logic signed [STEER_W-1:0] STEER_RST      = 9'sd0;
    localparam logic signed [STEER_W-1:0] STEER_REJECT   = -9'sd256;
    localparam logic [BASE_W-1:0]         BASE_FULL      = 8'd255;

    localparam logic signed [K_W-1:0]     K_BASE_MUL     = 20'sd1000;
    localparam logic signed [K_W-1:0]     K_STEER_MUL    = 20'sd400;
    localparam logic signed [T_W-1:0]     T_FULL         = 37'sd255000;
    localparam logic signed [T_W-1:0]     T_ZERO         = 37'sd0;

    // (T * 65536 + 127500) / 255000 == (T * 8192 + 15937) / 31875
    localparam logic [M_W-1:0]            RND_OFFSET     = 31'd15937;
    localparam logic [M_W-1:0]            DIVISOR        = 31'd31875;
    localparam logic [Q_W-1:0]            RECIP          = 17'd67372; // 2^31 / 31875
    localparam int                        RECIP_SH       = 31;

    localparam logic [THR_W-1:0]          THR_MAX        = 16'hFFFF;
    localparam logic [THR_W-1:0]          THR_OFF        = 16'h0000;

endpackage

FILE: design/qmpd_pd.sv
// ----------------------------------------------------------------------------
// qmpd_pd
// Proportional and derivative terms of both tilt axes, two stages.
// ----------------------------------------------------------------------------
module qmpd_pd
(
    input  logic                                    clk,
    input  qmpd_pkg::stage_vec_t                    load,
    input  logic        [qmpd_pkg::GAIN_W-1:0]      p_gain,
    input  logic        [qmpd_pkg::GAIN_W-1:0]      d_gain,
    input  logic signed [qmpd_pkg::SAMP_W-1:0]      tilt_y,
    input  logic signed [qmpd_pkg::SAMP_W-1:0]      tilt_z,
    input  logic signed [qmpd_pkg::SAMP_W-1:0]      rate_y,
    input  logic signed [qmpd_pkg::SAMP_W-1:0]      rate_z,
    output logic signed [qmpd_pkg::X_W-1:0]         x_y,
    output logic signed [qmpd_pkg::X_W-1:0]         x_z
);

    logic signed [qmpd_pkg::PROD_W-1:0] ty_reg, ty_next;
    logic signed [qmpd_pkg::PROD_W-1:0] tz_reg, tz_next;
    logic signed [qmpd_pkg::PROD_W-1:0] ry_reg, ry_next;
    logic signed [qmpd_pkg::PROD_W-1:0] rz_reg, rz_next;
    logic signed [qmpd_pkg::X_W-1:0]    xy_reg, xy_next;
    logic signed [qmpd_pkg::X_W-1:0]    xz_reg, xz_next;
    logic signed [qmpd_pkg::GAIN_W:0]   p_s;
    logic signed [qmpd_pkg::GAIN_W:0]   d_s;

    always_comb
    begin
        p_s     = $signed({1'b0, p_gain});
        d_s     = $signed({1'b0, d_gain});
        ty_next = qmpd_pkg::PROD_W'(tilt_y) * qmpd_pkg::PROD_W'(p_s);
        tz_next = qmpd_pkg::PROD_W'(tilt_z) * qmpd_pkg::PROD_W'(p_s);
        ry_next = qmpd_pkg::PROD_W'(rate_y) * qmpd_pkg::PROD_W'(d_s);
        rz_next = qmpd_pkg::PROD_W'(rate_z) * qmpd_pkg::PROD_W'(d_s);
        xy_next = qmpd_pkg::X_W'(ty_reg) + qmpd_pkg::X_W'(ry_reg);
        xz_next = qmpd_pkg::X_W'(tz_reg) + qmpd_pkg::X_W'(rz_reg);
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            ty_reg <= ty_next;
            tz_reg <= tz_next;
            ry_reg <= ry_next;
            rz_reg <= rz_next;
        end
        if (load[2])
        begin
            xy_reg <= xy_next;
            xz_reg <= xz_next;
        end
    end

    assign x_y = xy_reg;
    assign x_z = xz_reg;

endmodule

FILE: design/qmpd_lane.sv
// ----------------------------------------------------------------------------
// qmpd_lane
// One motor: scale, mix, clamp and divide by 255000 with rounding, six stages.
// ----------------------------------------------------------------------------
module qmpd_lane
(
    input  logic                                    clk,
    input  qmpd_pkg::stage_vec_t                    load,
    input  logic                                    sub,
    input  logic        [qmpd_pkg::BASE_W-1:0]      gain,
    input  logic signed [qmpd_pkg::K_W-1:0]         k,
    input  logic signed [qmpd_pkg::X_W-1:0]         x,
    output logic        [qmpd_pkg::THR_W-1:0]       throttle
);

    logic signed [qmpd_pkg::MP_W-1:0] mp_reg, mp_next;
    logic signed [qmpd_pkg::T_W-1:0]  t;
    logic [qmpd_pkg::TL_W-1:0]        tl_reg;
    logic [qmpd_pkg::M_W-1:0]         m5_reg, m5_next;
    logic [qmpd_pkg::M_W-1:0]         m6_reg, m7_reg;
    logic [qmpd_pkg::QM_W-1:0]        qm;
    logic [qmpd_pkg::Q_W-1:0]         q6_reg, q7_reg;
    logic [qmpd_pkg::QD_W-1:0]        qd_full;
    logic [qmpd_pkg::M_W-1:0]         qd_reg;
    logic [qmpd_pkg::M_W-1:0]         r;
    logic [qmpd_pkg::Q_W-1:0]         q;
    logic [3:0]                       zero_reg;   // bit i belongs to stage i+4
    logic [3:0]                       sat_reg;
    logic [qmpd_pkg::THR_W-1:0]       thr_reg, thr_next;

    always_comb
    begin
        mp_next = qmpd_pkg::MP_W'(x) * qmpd_pkg::MP_W'($signed({1'b0, gain}));
        if (sub)
            t = qmpd_pkg::T_W'(k) - qmpd_pkg::T_W'(mp_reg);
        else
            t = qmpd_pkg::T_W'(k) + qmpd_pkg::T_W'(mp_reg);
        m5_next = {tl_reg, qmpd_pkg::FRAC_SH'(0)} + qmpd_pkg::RND_OFFSET;
        qm      = qmpd_pkg::QM_W'(m5_reg) * qmpd_pkg::QM_W'(qmpd_pkg::RECIP);
        qd_full = qmpd_pkg::QD_W'(q6_reg) * qmpd_pkg::QD_W'(qmpd_pkg::DIVISOR);
        r       = m7_reg - qd_reg;
        q       = q7_reg + qmpd_pkg::Q_W'(r >= qmpd_pkg::DIVISOR);
        if (zero_reg[3])
            thr_next = qmpd_pkg::THR_OFF;
        else if (sat_reg[3] || q[qmpd_pkg::Q_W-1])
            thr_next = qmpd_pkg::THR_MAX;
        else
            thr_next = q[qmpd_pkg::THR_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            mp_reg <= mp_next;
        end
        if (load[4])
        begin
            tl_reg      <= t[qmpd_pkg::TL_W-1:0];
            zero_reg[0] <= (t <= qmpd_pkg::T_ZERO);
            sat_reg[0]  <= (t >= qmpd_pkg::T_FULL);
        end
        if (load[5])
        begin
            m5_reg      <= m5_next;
            zero_reg[1] <= zero_reg[0];
            sat_reg[1]  <= sat_reg[0];
        end
        if (load[6])
        begin
            m6_reg      <= m5_reg;
            q6_reg      <= qm[qmpd_pkg::RECIP_SH +: qmpd_pkg::Q_W];
            zero_reg[2] <= zero_reg[1];
            sat_reg[2]  <= sat_reg[1];
        end
        if (load[7])
        begin
            m7_reg      <= m6_reg;
            q7_reg      <= q6_reg;
            qd_reg      <= qd_full[qmpd_pkg::M_W-1:0];
            zero_reg[3] <= zero_reg[2];
            sat_reg[3]  <= sat_reg[2];
        end
        if (load[8])
        begin
            thr_reg <= thr_next;
        end
    end

    assign throttle = thr_reg;

endmodule

FILE: design/quad_motor_pd_mixer_core.sv
// ----------------------------------------------------------------------------
// quad_motor_pd_mixer_core
// PD attitude correction and four-motor throttle mixer, eight-stage pipeline.
// ----------------------------------------------------------------------------
//  channel  | dir | signals                         | beat
//  ---------+-----+---------------------------------+-----------------------------
//  s_*      | in  | s_tvalid s_tready s_tdata s_tuser | one sample, arm or stop
//  m_*      | out | m_tvalid m_tready m_tdata        | four throttles
//  cfg_*    | in  | cfg_wr_en cfg_index cfg_data     | one register write
//
//  One beat per cycle enters unless the first stage is full and stalled; each armed
//  sample beat yields one throttle beat. The stages hold the PD products and sums,
//  then the scale, mix, clamp and reciprocal divide by 255000 in each motor lane.
//  Reset clears the armed flag, all stage valid bits and loads the register defaults.
//  Each stage holds while the next one is full and stalled; empty stages fill up.
// ----------------------------------------------------------------------------
module quad_motor_pd_mixer_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [63:0]                         s_tdata,   // tilt_y, tilt_z, rate_y, rate_z
    input  logic [1:0]                          s_tuser,   // operation
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [63:0]                         m_tdata,   // throttle_ne, _se, _sw, _nw
    input  logic                                cfg_wr_en,
    input  logic [qmpd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [qmpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [qmpd_pkg::GAIN_W-1:0]         p_gain_reg;
    logic [qmpd_pkg::GAIN_W-1:0]         d_gain_reg;
    logic [qmpd_pkg::BASE_W-1:0]         base_reg;
    logic signed [qmpd_pkg::STEER_W-1:0] north_reg;
    logic signed [qmpd_pkg::STEER_W-1:0] east_reg;
    logic signed [qmpd_pkg::STEER_W-1:0] steer_wr;
    logic                                armed_reg, armed_next;
    qmpd_pkg::stage_vec_t                valid_reg, valid_next;
    qmpd_pkg::stage_vec_t                adv;
    logic                                in_beat;
    logic                                in_sample;

    logic [qmpd_pkg::BASE_W-1:0]         gain_reg, gain_next;
    logic signed [qmpd_pkg::K_W-1:0]     k_ne_reg, k_se_reg, k_sw_reg, k_nw_reg;
    logic signed [qmpd_pkg::K_W-1:0]     k_base;
    logic signed [qmpd_pkg::K_W-1:0]     n_k, e_k;

    logic signed [qmpd_pkg::X_W-1:0]     x_y, x_z;
    logic [qmpd_pkg::THR_W-1:0]          thr_ne, thr_se, thr_sw, thr_nw;

    // register file
    assign steer_wr = $signed(cfg_data[qmpd_pkg::STEER_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_gain_reg <= qmpd_pkg::P_GAIN_RST;
            d_gain_reg <= qmpd_pkg::D_GAIN_RST;
            base_reg   <= qmpd_pkg::BASE_RST;
            north_reg  <= qmpd_pkg::STEER_RST;
            east_reg   <= qmpd_pkg::STEER_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                qmpd_pkg::REG_P_GAIN:      p_gain_reg <= cfg_data;
                qmpd_pkg::REG_D_GAIN:      d_gain_reg <= cfg_data;
                qmpd_pkg::REG_BASE_LEVEL:  base_reg   <= cfg_data[qmpd_pkg::BASE_W-1:0];
                qmpd_pkg::REG_NORTH_STEER:
                begin
                    if (steer_wr != qmpd_pkg::STEER_REJECT)
                        north_reg <= steer_wr;
                end
                qmpd_pkg::REG_EAST_STEER:
                begin
                    if (steer_wr != qmpd_pkg::STEER_REJECT)
                        east_reg <= steer_wr;
                end
                default: ;
            endcase
        end
    end

    // per-lane constant part of the numerator
    always_comb
    begin
        gain_next = qmpd_pkg::BASE_FULL - base_reg;
        k_base    = $signed(qmpd_pkg::K_W'(base_reg)) * qmpd_pkg::K_BASE_MUL;
        n_k       = qmpd_pkg::K_W'(north_reg) * qmpd_pkg::K_STEER_MUL;
        e_k       = qmpd_pkg::K_W'(east_reg) * qmpd_pkg::K_STEER_MUL;
    end

    always_ff @(posedge clk)
    begin
        gain_reg <= gain_next;
        k_ne_reg <= k_base + n_k + e_k;
        k_se_reg <= k_base - n_k + e_k;
        k_sw_reg <= k_base - n_k - e_k;
        k_nw_reg <= k_base + n_k - e_k;
    end

    // handshake and stage valids
    always_comb
    begin
        adv[qmpd_pkg::NUM_STAGES] = !valid_reg[qmpd_pkg::NUM_STAGES] || m_tready;
        for (int i = qmpd_pkg::NUM_STAGES - 1; i >= 1; i--)
            adv[i] = !valid_reg[i] || adv[i+1];

        in_beat   = s_tvalid && adv[1];
        in_sample = in_beat && (s_tuser == qmpd_pkg::OP_SAMPLE) && armed_reg;

        armed_next = armed_reg;
        if (in_beat && (s_tuser == qmpd_pkg::OP_ARM))
            armed_next = 1'b1;
        else if (in_beat && (s_tuser == qmpd_pkg::OP_STOP))
            armed_next = 1'b0;

        valid_next = valid_reg;
        if (adv[1])
            valid_next[1] = in_sample;
        for (int i = 2; i <= qmpd_pkg::NUM_STAGES; i++)
            if (adv[i])
                valid_next[i] = valid_reg[i-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            armed_reg <= armed_next;
            valid_reg <= valid_next;
        end
    end

    assign s_tready = adv[1];
    assign m_tvalid = valid_reg[qmpd_pkg::NUM_STAGES];

    qmpd_pd u_pd
    (
        .clk    (clk),
        .load   (adv),
        .p_gain (p_gain_reg),
        .d_gain (d_gain_reg),
        .tilt_y ($signed(s_tdata[15:0])),
        .tilt_z ($signed(s_tdata[31:16])),
        .rate_y ($signed(s_tdata[47:32])),
        .rate_z ($signed(s_tdata[63:48])),
        .x_y    (x_y),
        .x_z    (x_z)
    );

    qmpd_lane u_lane_ne
    (
        .clk      (clk),
        .load     (adv),
        .sub      (1'b1),
        .gain     (gain_reg),
        .k        (k_ne_reg),
        .x        (x_z),
        .throttle (thr_ne)
    );

    qmpd_lane u_lane_se
    (
        .clk      (clk),
        .load     (adv),
        .sub      (1'b0),
        .gain     (gain_reg),
        .k        (k_se_reg),
        .x        (x_y),
        .throttle (thr_se)
    );

    qmpd_lane u_lane_sw
    (
        .clk      (clk),
        .load     (adv),
        .sub      (1'b0),
        .gain     (gain_reg),
        .k        (k_sw_reg),
        .x        (x_z),
        .throttle (thr_sw)
    );

    qmpd_lane u_lane_nw
    (
        .clk      (clk),
        .load     (adv),
        .sub      (1'b1),
        .gain     (gain_reg),
        .k        (k_nw_reg),
        .x        (x_y),
        .throttle (thr_nw)
    );

    assign m_tdata = {thr_nw, thr_sw, thr_se, thr_ne};

    a_stop_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == qmpd_pkg::OP_STOP) |=> !armed_reg)
        else $error("armed flag survived a stop beat");

    a_entry_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(valid_reg[1]) |->
            $past(s_tvalid && s_tready && (s_tuser == qmpd_pkg::OP_SAMPLE) && armed_reg))
        else $error("pipeline entry without an armed sample beat");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg) && !m_tready |-> !s_tready)
        else $error("input taken while the pipeline is full and stalled");

endmodule
